@@ design/tsd_pkg.sv @@
// Shared types and constants of the TLV stream deframer.
package tsd_pkg;

	localparam int MAX_NESTING = 8;
	localparam int SP_W        = $clog2(MAX_NESTING + 1);
	localparam int SIDX_W      = $clog2(MAX_NESTING);
	localparam int POS_W       = 17;
	localparam int END_W       = POS_W + 1;
	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};
	localparam logic [4:0] TAG_EXT_CODE  = 5'h1f;
	localparam int TDATA_W     = 48;

	typedef enum logic [2:0] {
		PH_TAG1,
		PH_TAG2,
		PH_LEN1,
		PH_LENX,
		PH_VALUE,
		PH_TRAIL,
		PH_ERR
	} tsd_phase_t;

	typedef enum logic [2:0] {
		KIND_HDR_BYTE,
		KIND_HDR_DONE,
		KIND_VALUE,
		KIND_TRAIL,
		KIND_ERROR
	} tsd_kind_t;

	typedef enum logic [1:0] {
		ERR_NONE,
		ERR_OVERRUN,
		ERR_DEPTH,
		ERR_TRUNC
	} tsd_err_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_last;
	} tsd_item_t;

	typedef struct packed {
		tsd_kind_t   kind;
		logic [15:0] tag;
		logic [15:0] length;
		logic [3:0]  depth;
		logic        constructed;
		logic [7:0]  value_byte;
		logic        value_last;
		tsd_err_t    error_code;
	} tsd_result_t;

endpackage

@@ design/tsd_in_stage.sv @@
// Input register stage of the TLV stream deframer.
module tsd_in_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [7:0]        s_tdata,
	input  logic              s_tlast,
	input  logic              take,
	output logic              valid_s1,
	output tsd_pkg::tsd_item_t item_s1
);
	import tsd_pkg::*;

	assign s_tready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			item_s1.data_byte  <= s_tdata;
			item_s1.frame_last <= s_tlast;
		end
	end

endmodule

@@ design/tsd_core.sv @@
// Parser state and per-word decode of the TLV stream deframer.
module tsd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  tsd_pkg::tsd_item_t   item,
	output tsd_pkg::tsd_result_t result
);
	import tsd_pkg::*;

	tsd_phase_t        phase_q, phase_n;
	logic [7:0]        first_tag_q, first_tag_n;
	logic [15:0]       tag_q, tag_n;
	logic [15:0]       accum_q, accum_n;
	logic [6:0]        left_q, left_n;
	logic [6:0]        index_q, index_n;
	logic [POS_W-1:0]  pos_q, pos_n;
	logic [END_W-1:0]  stack_q [MAX_NESTING];
	logic [END_W-1:0]  stack_eff [MAX_NESTING];
	logic [SP_W-1:0]   sp_q, sp_push, sp_pop, sp_n;
	tsd_err_t          sticky_q, sticky_n;
	logic [END_W-1:0]  prim_end_q;

	logic [7:0]        b;
	logic              last;
	logic              hdr;
	logic              cons;
	logic [END_W-1:0]  hdr_end;
	logic              overrun;
	tsd_err_t          hdr_err;
	tsd_err_t          step_err;
	logic              push;
	logic              done;
	logic              value_end;
	logic              run;
	logic              trunc;

	assign b    = item.data_byte;
	assign last = item.frame_last;

	assign pos_n       = (pos_q < POS_MAX) ? pos_q + 1'b1 : POS_MAX;
	assign first_tag_n = (phase_q == PH_TAG1) ? b : first_tag_q;
	assign cons        = first_tag_n[5];
	assign hdr_end     = END_W'(pos_n) + END_W'(accum_n);
	assign overrun     = (sp_q != '0) && (hdr_end > stack_q[SIDX_W'(sp_q - 1'b1)]);
	assign value_end   = (phase_q == PH_VALUE) && ({1'b0, pos_n} >= prim_end_q);

	always_comb begin
		hdr_err = ERR_NONE;
		if (overrun) begin
			hdr_err = ERR_OVERRUN;
		end else if (cons && (sp_q >= SP_W'(MAX_NESTING))) begin
			hdr_err = ERR_DEPTH;
		end
	end

	always_comb begin
		tag_n   = tag_q;
		accum_n = accum_q;
		left_n  = left_q;
		index_n = index_q;
		hdr     = 1'b0;
		unique case (phase_q)
			PH_TAG1: begin
				tag_n   = {8'h00, b};
				accum_n = '0;
			end
			PH_TAG2: begin
				tag_n = {first_tag_q, b};
			end
			PH_LEN1: begin
				if (b[7]) begin
					accum_n = '0;
					if (b[6:0] != '0) begin
						left_n  = b[6:0];
						index_n = '0;
					end else begin
						hdr = 1'b1;
					end
				end else begin
					accum_n = {8'h00, b};
					hdr     = 1'b1;
				end
			end
			PH_LENX: begin
				if (index_q == 7'd0) begin
					accum_n = accum_q | {8'h00, b};
				end else if (index_q == 7'd1) begin
					accum_n = accum_q | {b, 8'h00};
				end
				index_n = index_q + 1'b1;
				left_n  = left_q - 1'b1;
				hdr     = (left_q == 7'd1);
			end
			default: begin
			end
		endcase
	end

	assign push = hdr && (hdr_err == ERR_NONE) && cons;
	assign done = value_end || push ||
		(hdr && (hdr_err == ERR_NONE) && !cons && (accum_n == '0));
	assign sp_push = sp_q + SP_W'(push);

	always_comb begin
		for (int i = 0; i < MAX_NESTING; i++) begin
			stack_eff[i] = (push && (SIDX_W'(sp_q) == SIDX_W'(i))) ? hdr_end : stack_q[i];
		end
	end

	always_comb begin
		sp_pop = sp_push;
		run    = 1'b1;
		for (int i = MAX_NESTING - 1; i >= 0; i--) begin
			if (SP_W'(i) < sp_push) begin
				if (run && (stack_eff[i] == {1'b0, pos_n})) begin
					sp_pop = SP_W'(i);
				end else begin
					run = 1'b0;
				end
			end
		end
	end

	always_comb begin
		phase_n  = phase_q;
		sticky_n = sticky_q;
		sp_n     = sp_push;
		unique case (phase_q)
			PH_TAG1:  phase_n = (b[4:0] == TAG_EXT_CODE) ? PH_TAG2 : PH_LEN1;
			PH_TAG2:  phase_n = PH_LEN1;
			PH_LEN1:  phase_n = b[7] && (b[6:0] != '0) ? PH_LENX : PH_LEN1;
			default:  phase_n = phase_q;
		endcase
		if (hdr) begin
			if (hdr_err != ERR_NONE) begin
				phase_n  = PH_ERR;
				sticky_n = hdr_err;
			end else if (!cons && (accum_n != '0)) begin
				phase_n = PH_VALUE;
			end
		end
		if (done) begin
			sp_n    = sp_pop;
			phase_n = (sp_pop == '0) ? PH_TRAIL : PH_TAG1;
		end
	end

	always_comb begin
		step_err = ERR_NONE;
		if (hdr) begin
			step_err = hdr_err;
		end else if (phase_q == PH_ERR) begin
			step_err = sticky_q;
		end
	end

	assign trunc = last && (step_err == ERR_NONE) && (phase_n != PH_TRAIL) &&
		(phase_n != PH_ERR);

	always_comb begin
		result             = '0;
		result.kind        = KIND_HDR_BYTE;
		result.tag         = tag_n;
		result.length      = accum_n;
		result.depth       = 4'(sp_q);
		result.constructed = cons;
		result.error_code  = ERR_NONE;
		if (trunc) begin
			result            = '0;
			result.kind       = KIND_ERROR;
			result.error_code = ERR_TRUNC;
		end else if (hdr) begin
			if (hdr_err != ERR_NONE) begin
				result            = '0;
				result.kind       = KIND_ERROR;
				result.error_code = hdr_err;
			end else begin
				result.kind = KIND_HDR_DONE;
			end
		end else if (phase_q == PH_VALUE) begin
			result.kind        = KIND_VALUE;
			result.constructed = 1'b0;
			result.value_byte  = b;
			result.value_last  = value_end;
		end else if (phase_q == PH_ERR) begin
			result            = '0;
			result.kind       = KIND_ERROR;
			result.error_code = sticky_q;
		end else if (phase_q == PH_TRAIL) begin
			result      = '0;
			result.kind = KIND_TRAIL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_TAG1;
			sp_q     <= '0;
			pos_q    <= '0;
			sticky_q <= ERR_NONE;
		end else if (fire) begin
			if (last) begin
				phase_q  <= PH_TAG1;
				sp_q     <= '0;
				pos_q    <= '0;
				sticky_q <= ERR_NONE;
			end else begin
				phase_q  <= phase_n;
				sp_q     <= sp_n;
				pos_q    <= pos_n;
				sticky_q <= sticky_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_tag_q <= '0;
			tag_q       <= '0;
			accum_q     <= '0;
			left_q      <= '0;
			index_q     <= '0;
		end else if (fire) begin
			first_tag_q <= first_tag_n;
			tag_q       <= tag_n;
			accum_q     <= accum_n;
			left_q      <= left_n;
			index_q     <= index_n;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && hdr && (hdr_err == ERR_NONE) && !cons) begin
			prim_end_q <= hdr_end;
		end
		if (fire && push) begin
			stack_q[SIDX_W'(sp_q)] <= hdr_end;
		end
	end

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(MAX_NESTING))
		else $error("Nesting pointer exceeds the stack depth.");

	a_frame_reset: assert property (@(posedge clk) disable iff (!arst_n)
		fire && last |=> (phase_q == PH_TAG1) && (sp_q == '0) && (sticky_q == ERR_NONE))
		else $error("State not cleared after the last word of a frame.");

	a_err_code: assert property (@(posedge clk) disable iff (!arst_n)
		fire |-> ((result.kind == KIND_ERROR) == (result.error_code != ERR_NONE)))
		else $error("Error code does not match the result kind.");

	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fire && (phase_q == PH_ERR) && !last |=> (phase_q == PH_ERR) &&
			(sticky_q == $past(sticky_q)))
		else $error("Error state left before the end of the frame.");

	a_err_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_ERR) |-> (sticky_q != ERR_NONE))
		else $error("Error state without a stored error code.");

endmodule

@@ design/tsd_out_stage.sv @@
// Result register stage of the TLV stream deframer.
module tsd_out_stage (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          load,
	input  tsd_pkg::tsd_result_t          result,
	output logic                          free,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tsd_pkg::TDATA_W-1:0]   m_tdata,
	output logic [2:0]                    m_tuser,
	output logic                          m_tlast
);
	import tsd_pkg::*;

	tsd_result_t res_s2;

	assign free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (free) begin
			m_tvalid <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (load && free) begin
			res_s2 <= result;
		end
	end

	assign m_tdata = {1'b0, res_s2.error_code, res_s2.value_byte, res_s2.constructed,
		res_s2.depth, res_s2.length, res_s2.tag};
	assign m_tuser = res_s2.kind;
	assign m_tlast = res_s2.value_last;

endmodule

@@ design/tlv_stream_deframer.sv @@
// Top level of the TLV stream deframer.
//
// The block takes one frame byte per word on the s_ side (s_tlast marks the
// final byte of a frame) and gives exactly one result word on the m_ side
// for each byte. m_tuser holds the result kind: header byte, header complete,
// value byte, trailing byte or error. m_tdata carries tag, length, nesting
// depth, constructed flag, value byte and error code; m_tlast marks the last
// value byte of a primitive element.
// A byte is decoded while it sits in the input register and its result is
// loaded into the output register when that register is free; the result
// word is offered from the output register, not combinationally.
// One byte is taken every cycle while the receiver keeps up; header decode,
// end-position compare to the open elements and stack pop are combinational.
// Reset clears the parser to wait for the first tag byte with no open
// elements. The last byte of a frame returns the parser to that state.
// When the receiver stalls, the result is held and the input register keeps
// one more byte; after that s_tready drops until the result is taken.
module tlv_stream_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [7:0]                  s_tdata,  // data_byte
	input  logic                        s_tlast,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	// tag[15:0], length[31:16], depth[35:32], constructed[36], value_byte[44:37],
	// error_code[46:45], zero fill[47]
	output logic [tsd_pkg::TDATA_W-1:0] m_tdata,
	output logic [2:0]                  m_tuser,  // kind
	output logic                        m_tlast
);
	import tsd_pkg::*;

	logic        valid_s1;
	tsd_item_t   item_s1;
	tsd_result_t result;
	logic        free;
	logic        fire;

	assign fire = valid_s1 && free;

	tsd_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.take     (free),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	tsd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.result (result)
	);

	tsd_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (valid_s1),
		.result   (result),
		.free     (free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

@@ tb/sv/tlv_stream_deframer_tb.sv @@
// Self-checking testbench for the TLV stream deframer with a byte-level parser predictor.
module tlv_stream_deframer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tsd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_NODES   = 32;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;
	logic                 s_tlast = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic [2:0]           m_tuser;
	logic                 m_tlast;

	tlv_stream_deframer dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tsd_item_t   pending_bytes[$];
	tsd_result_t expected_results[$];
	logic [7:0]  frame_buf[$];
	tsd_item_t   next_item;
	tsd_result_t seen_word;
	tsd_result_t want_word;
	int          tx_idle_pct = 0;
	int          rx_stall_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;
	int          mismatches = 0;
	int          words_seen = 0;
	int          cycles = 0;

	// Parser state mirrored from the block.
	tsd_phase_t  prs_phase;
	logic [7:0]  prs_first;
	logic [15:0] prs_tag;
	logic [15:0] prs_len;
	logic [6:0]  prs_len_left;
	logic [6:0]  prs_len_idx;
	logic [16:0] prs_pos;
	logic [17:0] prs_end[MAX_NESTING];
	logic [3:0]  prs_sp;
	tsd_err_t    prs_err;
	logic [17:0] prs_prim_end;

	// Frame tree built in preorder before it is serialized.
	int          node_cnt;
	int          nd_lvl[MAX_NODES];
	bit          nd_cons[MAX_NODES];
	int          nd_vlen[MAX_NODES];
	int          nd_form[MAX_NODES];
	logic [15:0] nd_decl[MAX_NODES];
	logic [7:0]  nd_t1[MAX_NODES];
	logic [7:0]  nd_t2[MAX_NODES];

	function automatic void clear_parser();
		prs_phase = PH_TAG1;
		prs_first = 8'h00;
		prs_tag = 16'h0000;
		prs_len = 16'h0000;
		prs_len_left = 7'd0;
		prs_len_idx = 7'd0;
		prs_pos = 17'd0;
		for (int i = 0; i < MAX_NESTING; i++)
			prs_end[i] = 18'd0;
		prs_sp = 4'd0;
		prs_err = ERR_NONE;
		prs_prim_end = 18'd0;
	endfunction

	function automatic tsd_result_t decode_byte(input logic [7:0] b, input logic last);
		tsd_result_t r;
		logic [16:0] pos;
		logic [17:0] end_pos;
		logic        cons;
		logic        hdr;
		logic        done;
		logic        vl;
		logic [3:0]  depth;
		tsd_kind_t   kind;
		tsd_err_t    err;
		pos = (prs_pos < POS_MAX) ? prs_pos + 17'd1 : POS_MAX;
		prs_pos = pos;
		kind = KIND_HDR_BYTE;
		err = ERR_NONE;
		hdr = 1'b0;
		done = 1'b0;
		vl = 1'b0;
		case (prs_phase)
			PH_TAG1: begin
				prs_first = b;
				prs_tag = {8'h00, b};
				prs_len = 16'h0000;
				prs_phase = (b[4:0] == TAG_EXT_CODE) ? PH_TAG2 : PH_LEN1;
			end
			PH_TAG2: begin
				prs_tag = {prs_first, b};
				prs_phase = PH_LEN1;
			end
			PH_LEN1: begin
				if (b[7]) begin
					prs_len = 16'h0000;
					if (b[6:0] != 7'd0) begin
						prs_len_left = b[6:0];
						prs_len_idx = 7'd0;
						prs_phase = PH_LENX;
					end else begin
						hdr = 1'b1;
					end
				end else begin
					prs_len = {8'h00, b};
					hdr = 1'b1;
				end
			end
			PH_LENX: begin
				if (prs_len_idx == 7'd0)
					prs_len[7:0] = prs_len[7:0] | b;
				else if (prs_len_idx == 7'd1)
					prs_len[15:8] = prs_len[15:8] | b;
				prs_len_idx = prs_len_idx + 7'd1;
				prs_len_left = prs_len_left - 7'd1;
				if (prs_len_left == 7'd0)
					hdr = 1'b1;
			end
			PH_VALUE: begin
				kind = KIND_VALUE;
				if ({1'b0, pos} >= prs_prim_end) begin
					vl = 1'b1;
					done = 1'b1;
				end
			end
			PH_ERR: begin
				kind = KIND_ERROR;
				err = prs_err;
			end
			default: begin
				kind = KIND_TRAIL;
			end
		endcase

		cons = prs_first[5];
		depth = prs_sp;

		if (hdr) begin
			end_pos = {1'b0, pos} + {2'b00, prs_len};
			kind = KIND_HDR_DONE;
			if (prs_sp > 4'd0 && end_pos > prs_end[SIDX_W'(prs_sp - 4'd1)]) begin
				err = ERR_OVERRUN;
			end else if (cons) begin
				if (prs_sp >= 4'(MAX_NESTING)) begin
					err = ERR_DEPTH;
				end else begin
					prs_end[SIDX_W'(prs_sp)] = end_pos;
					prs_sp = prs_sp + 4'd1;
					done = 1'b1;
				end
			end else if (prs_len != 16'h0000) begin
				prs_prim_end = end_pos;
				prs_phase = PH_VALUE;
			end else begin
				done = 1'b1;
			end
			if (err != ERR_NONE) begin
				kind = KIND_ERROR;
				prs_err = err;
				prs_phase = PH_ERR;
			end
		end

		if (done) begin
			while (prs_sp > 4'd0 && prs_end[SIDX_W'(prs_sp - 4'd1)] == {1'b0, pos})
				prs_sp = prs_sp - 4'd1;
			prs_phase = (prs_sp == 4'd0) ? PH_TRAIL : PH_TAG1;
		end

		if (last && err == ERR_NONE && prs_phase != PH_TRAIL && prs_phase != PH_ERR) begin
			kind = KIND_ERROR;
			err = ERR_TRUNC;
		end

		r = '0;
		r.kind = kind;
		r.error_code = err;
		if (kind != KIND_TRAIL && kind != KIND_ERROR) begin
			r.tag = prs_tag;
			r.length = prs_len;
			r.depth = depth;
			if (kind == KIND_VALUE) begin
				r.value_byte = b;
				r.value_last = vl;
			end else begin
				r.constructed = cons;
			end
		end
		if (last)
			clear_parser();
		return r;
	endfunction

	function automatic string fmt_result(input tsd_result_t r);
		return $sformatf("kind=%0d tag=%h len=%h depth=%0d cons=%b vbyte=%h vlast=%b err=%0d",
			r.kind, r.tag, r.length, r.depth, r.constructed, r.value_byte, r.value_last,
			r.error_code);
	endfunction

	function automatic int add_node(input int lvl, input int chain, input int max_lvl);
		logic [7:0] t1;
		bit         cons;
		cons = (lvl < chain) || (chain == 0 && lvl < max_lvl && $urandom_range(0, 99) < 45);
		t1 = 8'($urandom);
		t1[5] = cons;
		if ($urandom_range(0, 99) < 20)
			t1[4:0] = TAG_EXT_CODE;
		else if (t1[4:0] == TAG_EXT_CODE)
			t1[0] = 1'b0;
		nd_lvl[node_cnt] = lvl;
		nd_cons[node_cnt] = cons;
		nd_t1[node_cnt] = t1;
		nd_t2[node_cnt] = 8'($urandom);
		if (cons)
			nd_vlen[node_cnt] = 0;
		else if ($urandom_range(0, 99) < 4)
			nd_vlen[node_cnt] = int'($urandom_range(100, 400));
		else
			nd_vlen[node_cnt] = int'($urandom_range(0, 6));
		node_cnt++;
		if (!cons)
			return 0;
		return (lvl < chain) ? 1 : int'($urandom_range(0, 2));
	endfunction

	// Builds one top-level element into frame_buf. A nonzero chain forces that many
	// nested constructed levels; corrupt_pct is the chance that a declared length is off.
	function automatic void build_frame(input int chain, input int max_lvl, input int corrupt_pct);
		int kids[$];
		int acc[16];
		int i;
		int k;
		int lvl;
		int content;
		int r;
		node_cnt = 0;
		kids.push_back(add_node(0, chain, max_lvl));
		while (kids.size() > 0 && node_cnt < MAX_NODES) begin
			if (kids[kids.size() - 1] == 0) begin
				void'(kids.pop_back());
			end else begin
				kids[kids.size() - 1] = kids[kids.size() - 1] - 1;
				lvl = kids.size();
				kids.push_back(add_node(lvl, chain, max_lvl));
			end
		end

		for (i = 0; i < 16; i++)
			acc[i] = 0;
		for (i = node_cnt - 1; i >= 0; i--) begin
			lvl = nd_lvl[i];
			content = nd_cons[i] ? acc[lvl + 1] : nd_vlen[i];
			if (nd_cons[i])
				acc[lvl + 1] = 0;
			nd_decl[i] = 16'(content);
			if ($urandom_range(0, 99) < corrupt_pct)
				nd_decl[i] = ($urandom_range(0, 3) == 0) ? 16'hFFFF :
					16'(content + int'($urandom_range(1, 3)));
			r = int'($urandom_range(0, 99));
			if (nd_decl[i] == 16'h0000 && r < 20) begin
				nd_form[i] = 0;
			end else if (nd_decl[i] < 16'd128 && r < 65) begin
				nd_form[i] = -1;
			end else begin
				nd_form[i] = ($urandom_range(0, 99) < 4) ? int'($urandom_range(5, 127)) :
					int'($urandom_range(1, 3));
				if (nd_decl[i] > 16'd255 && nd_form[i] < 2)
					nd_form[i] = 2;
			end
			acc[lvl] += content + 2 + ((nd_t1[i][4:0] == TAG_EXT_CODE) ? 1 : 0) +
				((nd_form[i] > 0) ? nd_form[i] : 0);
		end

		frame_buf.delete();
		for (i = 0; i < node_cnt; i++) begin
			frame_buf.push_back(nd_t1[i]);
			if (nd_t1[i][4:0] == TAG_EXT_CODE)
				frame_buf.push_back(nd_t2[i]);
			if (nd_form[i] < 0) begin
				frame_buf.push_back(nd_decl[i][7:0]);
			end else begin
				frame_buf.push_back({1'b1, 7'(nd_form[i])});
				for (k = 0; k < nd_form[i]; k++)
					frame_buf.push_back((k == 0) ? nd_decl[i][7:0] :
						((k == 1) ? nd_decl[i][15:8] : 8'($urandom)));
			end
			if (!nd_cons[i])
				for (k = 0; k < nd_vlen[i]; k++)
					frame_buf.push_back(8'($urandom));
		end
	endfunction

	function automatic void send_frame();
		tsd_item_t it;
		for (int i = 0; i < frame_buf.size(); i++) begin
			it.data_byte = frame_buf[i];
			it.frame_last = (i == frame_buf.size() - 1);
			pending_bytes.push_back(it);
		end
	endfunction

	// Mostly well-formed frames with random content; the rest are cut short,
	// carry bad lengths, nest deep (some past the stack depth), or are plain noise.
	function automatic void queue_random(input int n_items);
		int added;
		int sel;
		int cut;
		added = 0;
		while (added < n_items) begin
			sel = int'($urandom_range(0, 99));
			if (sel < 88) begin
				if (sel < 70)
					build_frame(0, int'($urandom_range(0, 3)), 0);
				else if (sel < 80)
					build_frame(0, int'($urandom_range(1, 3)), 15);
				else
					build_frame(int'($urandom_range(7, 10)), 0, 0);
				if (sel < 55) begin
					repeat ($urandom_range(0, 3))
						frame_buf.push_back(8'($urandom));
				end else if (sel < 70) begin
					cut = int'($urandom_range(1, frame_buf.size()));
					while (frame_buf.size() > cut)
						void'(frame_buf.pop_back());
				end
			end else begin
				frame_buf.delete();
				repeat ($urandom_range(1, 12))
					frame_buf.push_back(8'($urandom));
			end
			added += frame_buf.size();
			send_frame();
		end
	endfunction

	task automatic wait_idle();
		while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic run_phase(input int tx, input int rx, input int n_items, input bit hold);
		tx_idle_pct = tx;
		rx_stall_pct = rx;
		queue_random(n_items);
		if (hold)
			hold_req++;
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				expected_results.push_back(decode_byte(s_tdata, s_tlast));
			if (!s_tvalid || s_tready) begin
				if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
					next_item = pending_bytes.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= next_item.data_byte;
					s_tlast <= next_item.frame_last;
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left > 0) begin
			m_tready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_seen != hold_req) begin
			hold_seen <= hold_req;
			hold_left <= HOLD_CYCLES;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			seen_word.kind = tsd_kind_t'(m_tuser);
			seen_word.tag = m_tdata[15:0];
			seen_word.length = m_tdata[31:16];
			seen_word.depth = m_tdata[35:32];
			seen_word.constructed = m_tdata[36];
			seen_word.value_byte = m_tdata[44:37];
			seen_word.value_last = m_tlast;
			seen_word.error_code = tsd_err_t'(m_tdata[46:45]);
			if (expected_results.size() == 0) begin
				if (mismatches < 10)
					$display("word %0d arrived with nothing expected: %s", words_seen,
						fmt_result(seen_word));
				mismatches++;
			end else begin
				want_word = expected_results.pop_front();
				if (seen_word !== want_word) begin
					if (mismatches < 10) begin
						$display("word %0d differs", words_seen);
						$display("  expected %s", fmt_result(want_word));
						$display("  actual   %s", fmt_result(seen_word));
					end
					mismatches++;
				end
			end
			words_seen++;
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	initial begin
		clear_parser();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		frame_buf = '{8'hFF, 8'hFF, 8'h82, 8'hFF, 8'hFF, 8'h00};
		send_frame();
		frame_buf = '{8'h00, 8'h80, 8'hFF};
		send_frame();
		frame_buf = '{8'h1E, 8'h83, 8'h02, 8'h00, 8'h55, 8'h01, 8'h02};
		send_frame();
		frame_buf = '{8'h20, 8'h00};
		send_frame();
		frame_buf = '{8'h20, 8'h03, 8'h01, 8'h05, 8'hAA};
		send_frame();
		// Nine nested constructed headers that all end at the same byte.
		frame_buf.delete();
		for (int k = 0; k <= MAX_NESTING; k++) begin
			frame_buf.push_back(8'h20);
			frame_buf.push_back(8'(16 - 2 * k));
		end
		send_frame();
		wait_idle();

		run_phase(0, 0, 282, 1'b0);
		run_phase(85, 0, 282, 1'b0);
		run_phase(0, 85, 282, 1'b0);
		run_phase(25, 25, 282, 1'b0);
		run_phase(0, 0, 282, 1'b1);

		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

@@ filelist.f @@
design/tsd_pkg.sv
design/tsd_in_stage.sv
design/tsd_core.sv
design/tsd_out_stage.sv
design/tlv_stream_deframer.sv
tb/sv/tlv_stream_deframer_tb.sv
